FILE: rtl/core/i2cseq_pkg.sv
package i2cseq_pkg;

    localparam int DEF_BUFFER_DEPTH = 64;

    localparam int OP_W    = 2;
    localparam int IDX_W   = 6;
    localparam int BYTE_W  = 8;
    localparam int LEN_W   = 7;
    localparam int TMO_W   = 24;
    localparam int STATE_W = 3;
    localparam int ACK_W   = 2;

    localparam int CFG_ADDR_W = 4;
    localparam int CFG_DATA_W = 32;

    localparam logic [TMO_W-1:0] TMO_MAX = {TMO_W{1'b1}};

    // opcodes of an input request
    localparam logic [OP_W-1:0] OP_LOAD   = 2'd0;
    localparam logic [OP_W-1:0] OP_STATUS = 2'd1;
    localparam logic [OP_W-1:0] OP_START  = 2'd2;
    localparam logic [OP_W-1:0] OP_TICK   = 2'd3;

    // transfer state codes
    localparam logic [STATE_W-1:0] MS_IDLE      = 3'd0;
    localparam logic [STATE_W-1:0] MS_BUSY      = 3'd1;
    localparam logic [STATE_W-1:0] MS_OK        = 3'd2;
    localparam logic [STATE_W-1:0] MS_NO_DATA   = 3'd3;
    localparam logic [STATE_W-1:0] MS_NACK_ADDR = 3'd4;
    localparam logic [STATE_W-1:0] MS_NACK_DATA = 3'd5;
    localparam logic [STATE_W-1:0] MS_ARB_LOST  = 3'd6;
    localparam logic [STATE_W-1:0] MS_TIMEOUT   = 3'd7;

    // acknowledge control
    localparam logic [ACK_W-1:0] ACK_KEEP = 2'd0;
    localparam logic [ACK_W-1:0] ACK_ACK  = 2'd1;
    localparam logic [ACK_W-1:0] ACK_NACK = 2'd2;

    // controller status codes
    localparam logic [BYTE_W-1:0] SC_START       = 8'h08;
    localparam logic [BYTE_W-1:0] SC_RESTART     = 8'h10;
    localparam logic [BYTE_W-1:0] SC_SLA_W_ACK   = 8'h18;
    localparam logic [BYTE_W-1:0] SC_SLA_W_NACK  = 8'h20;
    localparam logic [BYTE_W-1:0] SC_DATA_W_ACK  = 8'h28;
    localparam logic [BYTE_W-1:0] SC_DATA_W_NACK = 8'h30;
    localparam logic [BYTE_W-1:0] SC_SLA_R_ACK   = 8'h40;
    localparam logic [BYTE_W-1:0] SC_SLA_R_NACK  = 8'h48;
    localparam logic [BYTE_W-1:0] SC_DATA_R_ACK  = 8'h50;
    localparam logic [BYTE_W-1:0] SC_DATA_R_NACK = 8'h58;

    // register indexes (word address)
    localparam logic [1:0] REG_WRITE_LENGTH  = 2'd0;
    localparam logic [1:0] REG_READ_LENGTH   = 2'd1;
    localparam logic [1:0] REG_TIMEOUT_LIMIT = 2'd2;

    typedef struct packed {
        logic [LEN_W-1:0] write_length;
        logic [LEN_W-1:0] read_length;
        logic [TMO_W-1:0] timeout_limit;
    } cfg_t;

    typedef struct packed {
        logic               tx_valid;
        logic               set_start;
        logic               set_stop;
        logic [ACK_W-1:0]   ack_control;
        logic               clear_interrupt;
        logic               clear_start;
        logic               rx_valid;
        logic [IDX_W-1:0]   rx_index;
        logic [BYTE_W-1:0]  rx_data;
        logic [STATE_W-1:0] transfer_state;
    } result_t;

endpackage

FILE: rtl/core/i2cseq_if.sv
interface i2cseq_req_if;
    import i2cseq_pkg::*;

    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   opcode;
    logic [IDX_W-1:0]  load_index;
    logic [BYTE_W-1:0] load_byte;
    logic [BYTE_W-1:0] status_code;
    logic [BYTE_W-1:0] rx_byte;

    modport source (output valid, opcode, load_index, load_byte, status_code, rx_byte,
                    input ready);
    modport sink (input valid, opcode, load_index, load_byte, status_code, rx_byte,
                  output ready);
endinterface

interface i2cseq_rsp_if;
    import i2cseq_pkg::*;

    logic               valid;
    logic               ready;
    logic               tx_valid;
    logic [BYTE_W-1:0]  tx_byte;
    logic               set_start;
    logic               set_stop;
    logic [ACK_W-1:0]   ack_control;
    logic               clear_interrupt;
    logic               clear_start;
    logic               rx_valid;
    logic [IDX_W-1:0]   rx_index;
    logic [BYTE_W-1:0]  rx_data;
    logic [STATE_W-1:0] transfer_state;

    modport source (output valid, tx_valid, tx_byte, set_start, set_stop, ack_control,
                    clear_interrupt, clear_start, rx_valid, rx_index, rx_data,
                    transfer_state,
                    input ready);
    modport sink (input valid, tx_valid, tx_byte, set_start, set_stop, ack_control,
                  clear_interrupt, clear_start, rx_valid, rx_index, rx_data,
                  transfer_state,
                  output ready);
endinterface

FILE: rtl/core/i2c_master_transfer_sequencer_top.sv
// Channel   Dir  Handshake            Payload
// req       in   valid/ready          opcode, load_index, load_byte, status_code, rx_byte
// rsp       out  valid/ready          tx byte, start/stop, ack, clears, rx byte, state
// apb       in   psel/penable/pwrite  write_length, read_length, timeout_limit at 4*i
//
// One request per cycle while rsp.ready is high, every request gives exactly one
// response. A request passes the decode stage (write buffer read issued) and
// then the output register, where the registered read data joins it. rst_n
// clears positions, state, timeout count and both valid flags; the write
// buffer is not cleared. A stalled rsp fills the output register first, then
// the decode stage, and only then drops req.ready.
module i2c_master_transfer_sequencer_top #(
    parameter int BufferDepth = i2cseq_pkg::DEF_BUFFER_DEPTH
) (
    input  logic                              clk,
    input  logic                              rst_n,
    i2cseq_req_if.sink                        req,
    i2cseq_rsp_if.source                      rsp,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [i2cseq_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [i2cseq_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [i2cseq_pkg::CFG_DATA_W-1:0] prdata,
    output logic                              pready
);
    import i2cseq_pkg::*;

    // positions saturate at BufferDepth itself, so they need one extra code
    localparam int POS_W  = $clog2(BufferDepth + 1);
    localparam int ADDR_W = $clog2(BufferDepth);
    localparam int CMP_W  = (POS_W + 1 > 8) ? POS_W + 1 : 8;
    localparam logic [CMP_W-1:0] DEPTH_C = CMP_W'(BufferDepth);

    cfg_t cfg;

    i2cseq_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    assign pready = 1'b1;

    // write buffer
    logic [BYTE_W-1:0] wbuf_mem [BufferDepth];
    logic [BYTE_W-1:0] rd_data_reg;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;

    // sequencer state
    logic [POS_W-1:0]   wpos_reg, wpos_next;
    logic [POS_W-1:0]   rpos_reg, rpos_next;
    logic [STATE_W-1:0] ms_reg, ms_next;
    logic [TMO_W-1:0]   tcnt_reg, tcnt_next;

    // pipeline
    logic    s1_valid_reg, s1_valid_next;
    result_t s1_res_reg;
    logic    out_valid_reg, out_valid_next;
    result_t out_res_reg;
    logic [BYTE_W-1:0] out_tx_byte_reg;
    logic    s1_adv;
    logic    accept;

    // decode scratch
    result_t          res;
    logic             do_send;
    logic [POS_W-1:0] send_pos;
    logic             do_take;
    logic             do_ack;
    logic [CMP_W-1:0] wpos_ext;
    logic [CMP_W-1:0] rpos_ext;
    logic [CMP_W-1:0] send_ext;
    logic [CMP_W-1:0] rnext_ext;
    logic [CMP_W-1:0] load_ext;
    logic [CMP_W-1:0] wlen_ext;
    logic [CMP_W-1:0] rlen_ext;

    // advance the decode stage when the output register is free or drains now
    assign s1_adv    = s1_valid_reg && (!out_valid_reg || rsp.ready);
    assign req.ready = !s1_valid_reg || s1_adv;
    assign accept    = req.valid && req.ready;

    assign wpos_ext = CMP_W'(wpos_reg);
    assign rpos_ext = CMP_W'(rpos_reg);
    assign load_ext = CMP_W'(req.load_index);
    assign wlen_ext = CMP_W'(cfg.write_length);
    assign rlen_ext = CMP_W'(cfg.read_length);

    always_comb
    begin
        wpos_next = wpos_reg;
        rpos_next = rpos_reg;
        ms_next   = ms_reg;
        tcnt_next = tcnt_reg;
        res       = '0;
        do_send   = 1'b0;
        send_pos  = wpos_reg;
        do_take   = 1'b0;
        do_ack    = 1'b0;
        send_ext  = '0;
        rnext_ext = '0;

        case (req.opcode)
            OP_LOAD:
            begin
                // out-of-range loads are dropped at the memory write enable
            end
            OP_STATUS:
            begin
                tcnt_next           = '0;
                res.clear_interrupt = 1'b1;
                case (req.status_code)
                    SC_START:
                    begin
                        send_pos        = '0;
                        do_send         = 1'b1;
                        res.clear_start = 1'b1;
                    end
                    SC_RESTART:
                    begin
                        rpos_next       = '0;
                        do_send         = 1'b1;
                        res.clear_start = 1'b1;
                    end
                    SC_SLA_W_ACK:
                    begin
                        if (cfg.write_length == LEN_W'(1))
                        begin
                            res.set_stop = 1'b1;
                            ms_next      = MS_NO_DATA;
                        end
                        else
                        begin
                            do_send = 1'b1;
                        end
                    end
                    // an address NACK in the write phase behaves like a data ACK
                    SC_SLA_W_NACK, SC_DATA_W_ACK:
                    begin
                        if (wpos_ext < wlen_ext)
                        begin
                            do_send = 1'b1;
                        end
                        else if (cfg.read_length != '0)
                        begin
                            res.set_start = 1'b1;
                        end
                        else
                        begin
                            res.set_stop = 1'b1;
                            ms_next      = MS_OK;
                        end
                    end
                    SC_DATA_W_NACK:
                    begin
                        res.set_stop = 1'b1;
                        ms_next      = MS_NACK_DATA;
                    end
                    SC_SLA_R_ACK:
                    begin
                        do_ack = 1'b1;
                    end
                    SC_DATA_R_ACK:
                    begin
                        do_take = 1'b1;
                        do_ack  = 1'b1;
                    end
                    SC_DATA_R_NACK:
                    begin
                        do_take      = 1'b1;
                        ms_next      = MS_OK;
                        res.set_stop = 1'b1;
                    end
                    SC_SLA_R_NACK:
                    begin
                        res.set_stop = 1'b1;
                        ms_next      = MS_NACK_ADDR;
                    end
                    default:
                    begin
                        // arbitration lost and every unknown code
                        ms_next = MS_ARB_LOST;
                    end
                endcase
            end
            OP_START:
            begin
                ms_next       = MS_BUSY;
                tcnt_next     = '0;
                res.set_start = 1'b1;
            end
            default:
            begin
                // tick: count only while busy
                if (ms_reg == MS_BUSY)
                begin
                    if (tcnt_reg >= cfg.timeout_limit)
                    begin
                        ms_next             = MS_TIMEOUT;
                        res.set_stop        = 1'b1;
                        res.clear_start     = 1'b1;
                        res.clear_interrupt = 1'b1;
                    end
                    else if (tcnt_reg != TMO_MAX)
                    begin
                        tcnt_next = tcnt_reg + TMO_W'(1);
                    end
                end
            end
        endcase

        // send the byte at send_pos unless the position sits at the buffer end
        send_ext = CMP_W'(send_pos);
        if (do_send && (send_ext < DEPTH_C))
        begin
            res.tx_valid = 1'b1;
            wpos_next    = send_pos + POS_W'(1);
        end

        // take the received byte unless the read position sits at the buffer end
        if (do_take && (rpos_ext < DEPTH_C))
        begin
            res.rx_valid = 1'b1;
            res.rx_index = rpos_ext[IDX_W-1:0];
            res.rx_data  = req.rx_byte;
            rpos_next    = rpos_reg + POS_W'(1);
        end

        // ACK while more bytes follow the next one, NACK the last
        if (do_ack)
        begin
            rnext_ext       = CMP_W'(rpos_next) + CMP_W'(1);
            res.ack_control = (rnext_ext < rlen_ext) ? ACK_ACK : ACK_NACK;
        end

        res.transfer_state = ms_next;
    end

    assign wr_en   = accept && (req.opcode == OP_LOAD) && (load_ext < DEPTH_C);
    assign wr_addr = load_ext[ADDR_W-1:0];
    assign rd_en   = accept && res.tx_valid;
    assign rd_addr = send_ext[ADDR_W-1:0];

    // write buffer: one write and one registered read per cycle; the read data
    // holds while the decode stage is stalled since no request is taken then
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            wbuf_mem[wr_addr] <= req.load_byte;
        end
        if (rd_en)
        begin
            rd_data_reg <= wbuf_mem[rd_addr];
        end
    end

    always_comb
    begin
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end

        if (s1_adv)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wpos_reg      <= '0;
            rpos_reg      <= '0;
            ms_reg        <= MS_IDLE;
            tcnt_reg      <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                wpos_reg <= wpos_next;
                rpos_reg <= rpos_next;
                ms_reg   <= ms_next;
                tcnt_reg <= tcnt_next;
            end
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers: hold unless the stage loads
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_res_reg <= res;
        end
        if (s1_adv)
        begin
            out_res_reg     <= s1_res_reg;
            out_tx_byte_reg <= s1_res_reg.tx_valid ? rd_data_reg : '0;
        end
    end

    assign rsp.valid           = out_valid_reg;
    assign rsp.tx_valid        = out_res_reg.tx_valid;
    assign rsp.tx_byte         = out_tx_byte_reg;
    assign rsp.set_start       = out_res_reg.set_start;
    assign rsp.set_stop        = out_res_reg.set_stop;
    assign rsp.ack_control     = out_res_reg.ack_control;
    assign rsp.clear_interrupt = out_res_reg.clear_interrupt;
    assign rsp.clear_start     = out_res_reg.clear_start;
    assign rsp.rx_valid        = out_res_reg.rx_valid;
    assign rsp.rx_index        = out_res_reg.rx_index;
    assign rsp.rx_data         = out_res_reg.rx_data;
    assign rsp.transfer_state  = out_res_reg.transfer_state;

endmodule

FILE: rtl/core/i2cseq_regs.sv
module i2cseq_regs (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [i2cseq_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [i2cseq_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [i2cseq_pkg::CFG_DATA_W-1:0] prdata,
    output i2cseq_pkg::cfg_t                  cfg
);
    import i2cseq_pkg::*;

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic [1:0] reg_idx;
    logic       wr_en;

    assign reg_idx = paddr[3:2];
    assign wr_en   = psel && penable && pwrite;
    assign cfg     = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (reg_idx)
                REG_WRITE_LENGTH:  cfg_next.write_length  = pwdata[LEN_W-1:0];
                REG_READ_LENGTH:   cfg_next.read_length   = pwdata[LEN_W-1:0];
                REG_TIMEOUT_LIMIT: cfg_next.timeout_limit = pwdata[TMO_W-1:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_WRITE_LENGTH:  prdata = {{(CFG_DATA_W-LEN_W){1'b0}}, cfg_reg.write_length};
            REG_READ_LENGTH:   prdata = {{(CFG_DATA_W-LEN_W){1'b0}}, cfg_reg.read_length};
            REG_TIMEOUT_LIMIT: prdata = {{(CFG_DATA_W-TMO_W){1'b0}}, cfg_reg.timeout_limit};
            default:           prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.write_length  <= '0;
            cfg_reg.read_length   <= '0;
            cfg_reg.timeout_limit <= TMO_MAX;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule
